FILE: hw/rtl/ttc_pkg.sv
// Shared types and constants of the text terminal cell engine.
// Holds field widths, opcodes, character codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package ttc_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;

  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // Address register load selects
  localparam logic [2:0] ADDR_HOLD   = 3'd0;
  localparam logic [2:0] ADDR_CURSOR = 3'd1;
  localparam logic [2:0] ADDR_BACK   = 3'd2;
  localparam logic [2:0] ADDR_READ   = 3'd3;
  localparam logic [2:0] ADDR_TOPROW = 3'd4;
  localparam logic [2:0] ADDR_ZERO   = 3'd5;
  localparam logic [2:0] ADDR_INC    = 3'd6;

  // Cursor updates
  localparam logic [2:0] CUR_HOLD    = 3'd0;
  localparam logic [2:0] CUR_HOME    = 3'd1;
  localparam logic [2:0] CUR_ADVANCE = 3'd2;
  localparam logic [2:0] CUR_NEWLINE = 3'd3;
  localparam logic [2:0] CUR_BACK    = 3'd4;
  localparam logic [2:0] CUR_SCROLL  = 3'd5;

  typedef struct packed {
    logic       latch;
    logic [2:0] addr_sel;
    logic       mem_we;
    logic       wr_space;
    logic [2:0] cur_op;
    logic       out_load;
    logic       out_cell;
  } ttc_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                is_nl;
    logic                is_bs;
    logic                at_origin;
    logic                wrap;
    logic                line_last;
    logic                read_ok;
    logic                cnt_last_row;
    logic                cnt_last_all;
    logic                out_free;
  } ttc_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ttc_in_if.sv
// Command channel of the text terminal cell engine: valid/ready plus one item.
// Depends on ttc_pkg for field widths.
`default_nettype none

interface ttc_in_if;
  import ttc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAR_W-1:0]   char_code;
  logic [ROW_W-1:0]    read_row;
  logic [COL_W-1:0]    read_col;

  modport source (output valid, opcode, char_code, read_row, read_col, input ready);
  modport sink   (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ttc_out_if.sv
// Result channel of the text terminal cell engine: valid/ready plus one result word.
// Depends on ttc_pkg for field widths.
`default_nettype none

interface ttc_out_if;
  import ttc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  modport source (output valid, cell_char, cursor_col, cursor_row, input ready);
  modport sink   (input valid, cell_char, cursor_col, cursor_row, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ttc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module ttc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ttc_ctrl.sv
// Sequencing state machine of the text terminal cell engine.
// Depends on ttc_pkg; drives ttc_cmd_t to the datapath and reads ttc_sts_t back.
`default_nettype none

module ttc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ttc_pkg::ttc_sts_t sts,
  output ttc_pkg::ttc_cmd_t      cmd
);
  import ttc_pkg::*;

  localparam logic [2:0] S_INIT      = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_EXEC      = 3'd2;
  localparam logic [2:0] S_WRITE     = 3'd3;
  localparam logic [2:0] S_READ      = 3'd4;
  localparam logic [2:0] S_BLANK_ROW = 3'd5;
  localparam logic [2:0] S_BLANK_ALL = 3'd6;
  localparam logic [2:0] S_RESP      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.mem_we   = 1'b1;
        cmd.wr_space = 1'b1;
        cmd.addr_sel = ADDR_INC;
        if (sts.cnt_last_all) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        case (sts.op)
          OP_PUT: begin
            if (sts.is_nl) begin
              if (sts.line_last) begin
                cmd.cur_op   = CUR_SCROLL;
                cmd.addr_sel = ADDR_TOPROW;
                state_next   = S_BLANK_ROW;
              end else begin
                cmd.cur_op = CUR_NEWLINE;
              end
            end else if (sts.is_bs) begin
              if (!sts.at_origin) begin
                cmd.addr_sel = ADDR_BACK;
                cmd.cur_op   = CUR_BACK;
                state_next   = S_WRITE;
              end
            end else begin
              cmd.addr_sel = ADDR_CURSOR;
              state_next   = S_WRITE;
            end
          end
          OP_CLEAR: begin
            cmd.addr_sel = ADDR_ZERO;
            cmd.cur_op   = CUR_HOME;
            state_next   = S_BLANK_ALL;
          end
          OP_READ: begin
            if (sts.read_ok) begin
              cmd.addr_sel = ADDR_READ;
              state_next   = S_READ;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_WRITE: begin
        cmd.mem_we   = 1'b1;
        cmd.wr_space = sts.is_bs;
        state_next   = S_RESP;
        if (!sts.is_bs) begin
          if (sts.wrap && sts.line_last) begin
            cmd.cur_op   = CUR_SCROLL;
            cmd.addr_sel = ADDR_TOPROW;
            state_next   = S_BLANK_ROW;
          end else begin
            cmd.cur_op = CUR_ADVANCE;
          end
        end
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_BLANK_ROW: begin
        cmd.mem_we   = 1'b1;
        cmd.wr_space = 1'b1;
        cmd.addr_sel = ADDR_INC;
        if (sts.cnt_last_row) begin
          state_next = S_RESP;
        end
      end
      S_BLANK_ALL: begin
        cmd.mem_we   = 1'b1;
        cmd.wr_space = 1'b1;
        cmd.addr_sel = ADDR_INC;
        if (sts.cnt_last_all) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_cell = (sts.op == OP_READ) && sts.read_ok;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_EXEC)
    else $error("accepted word did not enter execute");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESP || state == S_READ) |-> !cmd.mem_we)
    else $error("memory write outside a write or sweep step");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  a_row_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLANK_ROW && sts.cnt_last_row) |=> state == S_RESP)
    else $error("row blanking did not finish");

endmodule

`default_nettype wire

FILE: hw/rtl/ttc_dp.sv
// Datapath of the text terminal cell engine: item latch, cursor, scroll offset,
// address generation, cell RAM and result register. Depends on ttc_pkg and ttc_ram.
`default_nettype none

module ttc_dp #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [ttc_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [ttc_pkg::CHAR_W-1:0]   in_char_code,
  input  wire logic [ttc_pkg::ROW_W-1:0]    in_read_row,
  input  wire logic [ttc_pkg::COL_W-1:0]    in_read_col,
  input  wire ttc_pkg::ttc_cmd_t            cmd,
  output ttc_pkg::ttc_sts_t                 sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ttc_pkg::CHAR_W-1:0]        out_cell_char,
  output logic [ttc_pkg::COL_W-1:0]         out_cursor_col,
  output logic [ttc_pkg::ROW_W-1:0]         out_cursor_row
);
  import ttc_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  // Latched item
  logic [OPCODE_W-1:0] item_op;
  logic [CHAR_W-1:0]   item_char;
  logic [ROW_W-1:0]    item_row;
  logic [COL_W-1:0]    item_col;

  // Cursor and physical row holding logical row 0
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_line;
  logic [RW-1:0] top_row;

  logic [AW-1:0] addr;
  logic [AW-1:0] cnt;
  logic [AW-1:0] addr_calc;

  logic [CHAR_W-1:0] rdata;
  logic [CHAR_W-1:0] wdata;

  logic          col_zero;
  logic [RW-1:0] lrow;
  logic [CW-1:0] lcol;
  logic          xlate;
  logic [RW:0]   row_sum;
  logic [RW-1:0] prow;
  logic [RW+ROW_W-1:0] row_ext;
  logic [CW+COL_W-1:0] col_ext;
  logic [CW+COL_W-1:0] cur_col_ext;
  logic [RW+ROW_W-1:0] cur_line_ext;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_op   <= in_opcode;
      item_char <= in_char_code;
      item_row  <= in_read_row;
      item_col  <= in_read_col;
    end
  end

  assign col_zero = (cur_col == '0);
  assign row_ext  = {{RW{1'b0}}, item_row};
  assign col_ext  = {{CW{1'b0}}, item_col};

  // Logical address position; cursor, back and read rows map through top_row
  always_comb begin
    lrow  = '0;
    lcol  = '0;
    xlate = 1'b1;
    case (cmd.addr_sel)
      ADDR_CURSOR: begin
        lrow = cur_line;
        lcol = cur_col;
      end
      ADDR_BACK: begin
        lrow = col_zero ? cur_line - RW'(1) : cur_line;
        lcol = col_zero ? CW'(COLS - 1) : cur_col - CW'(1);
      end
      ADDR_READ: begin
        lrow = row_ext[RW-1:0];
        lcol = col_ext[CW-1:0];
      end
      ADDR_TOPROW: begin
        lrow  = top_row;
        xlate = 1'b0;
      end
      default: begin
        xlate = 1'b0;
      end
    endcase
  end

  assign row_sum = {1'b0, lrow} + (xlate ? {1'b0, top_row} : '0);
  assign prow    = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS))
                                              : row_sum[RW-1:0];
  assign addr_calc = AW'(prow) * AW'(COLS) + AW'(lcol);

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      cnt  <= '0;
    end else if (cmd.addr_sel == ADDR_INC) begin
      addr <= addr + AW'(1);
      cnt  <= cnt + AW'(1);
    end else if (cmd.addr_sel != ADDR_HOLD) begin
      addr <= addr_calc;
      cnt  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_line <= '0;
      top_row  <= '0;
    end else begin
      case (cmd.cur_op)
        CUR_HOME: begin
          cur_col  <= '0;
          cur_line <= '0;
          top_row  <= '0;
        end
        CUR_ADVANCE: begin
          if (cur_col == CW'(COLS - 1)) begin
            cur_col  <= '0;
            cur_line <= cur_line + RW'(1);
          end else begin
            cur_col <= cur_col + CW'(1);
          end
        end
        CUR_NEWLINE: begin
          cur_col  <= '0;
          cur_line <= cur_line + RW'(1);
        end
        CUR_BACK: begin
          if (col_zero) begin
            cur_col  <= CW'(COLS - 1);
            cur_line <= cur_line - RW'(1);
          end else begin
            cur_col <= cur_col - CW'(1);
          end
        end
        CUR_SCROLL: begin
          cur_col  <= '0;
          cur_line <= RW'(ROWS - 1);
          top_row  <= (top_row == RW'(ROWS - 1)) ? '0 : top_row + RW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign wdata = cmd.wr_space ? CH_SPACE : item_char;

  ttc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (cmd.mem_we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_comb begin
    sts              = '0;
    sts.op           = item_op;
    sts.is_nl        = (item_char == CH_NEWLINE);
    sts.is_bs        = (item_char == CH_BACKSPACE);
    sts.at_origin    = col_zero && (cur_line == '0);
    sts.wrap         = (cur_col == CW'(COLS - 1));
    sts.line_last    = (cur_line == RW'(ROWS - 1));
    sts.read_ok      = (32'(item_row) < ROWS) && (32'(item_col) < COLS);
    sts.cnt_last_row = (cnt == AW'(COLS - 1));
    sts.cnt_last_all = (cnt == AW'(DEPTH - 1));
    sts.out_free     = !out_valid || out_ready;
  end

  assign cur_col_ext  = {{COL_W{1'b0}}, cur_col};
  assign cur_line_ext = {{ROW_W{1'b0}}, cur_line};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_char  <= cmd.out_cell ? rdata : '0;
      out_cursor_col <= cur_col_ext[COL_W-1:0];
      out_cursor_row <= cur_line_ext[ROW_W-1:0];
    end
  end

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    32'(cur_line) < ROWS)
    else $error("cursor row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(cur_col) < COLS)
    else $error("cursor column out of range");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    32'(top_row) < ROWS)
    else $error("scroll offset out of range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_cursor_col)
                                  && $stable(out_cursor_row))
    else $error("pending result dropped or changed");

endmodule

`default_nettype wire

FILE: hw/rtl/text_terminal_cell_engine_top.sv
// Top level of the text terminal cell engine: ROWS by COLS byte grid with cursor.
// Depends on ttc_pkg, ttc_in_if, ttc_out_if, ttc_ctrl, ttc_dp (and ttc_ram below it).
//
// Usage:
//   cmd carries one word per item: opcode (put, clear, read), char_code, read_row,
//   read_col. rsp returns exactly one word per item: cell_char (the cell for a
//   read in range, zero otherwise) and the cursor column and row after the item.
//   Both channels move a word on a rising edge with valid and ready high.
// Steps: each item is accepted, executed, then loaded as a result. A plain byte
//   or moving backspace adds a write, a read in range a RAM read; newline,
//   backspace at origin, read out of range or unused opcode add nothing; a
//   scrolling byte or newline adds a row of blanking and a clear a full sweep.
//   One item is in work at a time; the next is accepted in the cycle after the
//   result is loaded. The single RAM port writes one cell at a time, which is
//   why a scroll blanks a row and a clear sweeps all cells. Scrolling moves no
//   data: a top-row offset rotates the rows.
// Reset: rst (synchronous) homes the cursor and then sweeps spaces into all
//   ROWS*COLS cells, one per cycle; cmd.ready stays low for those cycles.
// Stall: a result held by rsp.ready low stays in its register; the engine keeps
//   accepting and working on the next word, and holds before loading its result.
`default_nettype none

module text_terminal_cell_engine_top #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ttc_in_if.sink     cmd,
  ttc_out_if.source  rsp
);
  import ttc_pkg::*;

  ttc_cmd_t ctl_cmd;
  ttc_sts_t ctl_sts;

  // Sequencer: owns the command handshake and steps each item
  ttc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  // Storage, cursor arithmetic and the result register
  ttc_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_opcode      (cmd.opcode),
    .in_char_code   (cmd.char_code),
    .in_read_row    (cmd.read_row),
    .in_read_col    (cmd.read_col),
    .cmd            (ctl_cmd),
    .sts            (ctl_sts),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_cell_char  (rsp.cell_char),
    .out_cursor_col (rsp.cursor_col),
    .out_cursor_row (rsp.cursor_row)
  );

endmodule

`default_nettype wire
